### rtl/fbpa_pkg.sv
// Shared widths, codes and types of the fixed block pool allocator.
`default_nettype none

package fbpa_pkg;

    // Payload widths of the request, response and configuration beats.
    localparam int REQ_W       = 2;
    localparam int OFFSET_W    = 20;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 9;
    localparam int FAIL_W      = 16;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_SIZE_W  = 13;
    localparam int CFG_COUNT_W = 9;

    // Effective block size after the alignment round-up and minimum clamp.
    localparam int SIZE_W = 14;

    // Register values after reset.
    localparam int CFG_SIZE_RST  = 8;
    localparam int CFG_COUNT_RST = 256;

    // Default geometry of the pool.
    localparam int MAX_BLOCKS_DEF = 256;
    localparam int ALIGNMENT_DEF  = 4;
    localparam int MIN_BLOCK_DEF  = 4;
    localparam int STK_IDX_W_DEF  = 8;

    // Request types.
    localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RESET = 2'd2;

    // Response status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_FREE  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 4'd1;

    // Shift control for the free stack cells.
    typedef struct packed {
        logic load;
        logic push;
        logic pop;
    } t_stk_ctl;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [OFFSET_W-1:0]    block_offset;
        logic [COUNT_OUT_W-1:0] blocks_in_use;
        logic [COUNT_OUT_W-1:0] peak_in_use;
        logic [FAIL_W-1:0]      failed_allocs;
    } t_result;

endpackage

`default_nettype wire

### rtl/fbpa_if.sv
// Request, response and configuration channel interfaces of the allocator.
`default_nettype none

interface fbpa_req_if;
    logic                           valid;
    logic                           ready;
    logic [fbpa_pkg::REQ_W-1:0]     req_type;
    logic [fbpa_pkg::OFFSET_W-1:0]  free_offset;

    modport source (output valid, output req_type, output free_offset, input ready);
    modport sink   (input valid, input req_type, input free_offset, output ready);
endinterface

interface fbpa_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [fbpa_pkg::STATUS_W-1:0]     status;
    logic [fbpa_pkg::OFFSET_W-1:0]     block_offset;
    logic [fbpa_pkg::COUNT_OUT_W-1:0]  blocks_in_use;
    logic [fbpa_pkg::COUNT_OUT_W-1:0]  peak_in_use;
    logic [fbpa_pkg::FAIL_W-1:0]       failed_allocs;

    modport source (output valid, output status, output block_offset, output blocks_in_use,
                    output peak_in_use, output failed_allocs, input ready);
    modport sink   (input valid, input status, input block_offset, input blocks_in_use,
                    input peak_in_use, input failed_allocs, output ready);
endinterface

interface fbpa_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [fbpa_pkg::CFG_IDX_W-1:0]   index;
    logic [fbpa_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/fbpa_cell.sv
// One entry of the free stack; shifts toward the top on pop and away from it on push.
`default_nettype none

module fbpa_cell #(
    parameter int IDX_W = fbpa_pkg::STK_IDX_W_DEF,
    parameter int IDX   = 0
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire fbpa_pkg::t_stk_ctl i_ctl,
    input  wire logic [IDX_W-1:0]   i_above,
    input  wire logic [IDX_W-1:0]   i_below,
    output logic      [IDX_W-1:0]   o_val
);

    logic [IDX_W-1:0] r_val;

    // A rebuilt list holds block k at depth k from the top.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.load) begin
            r_val <= IDX_W'(IDX);
        end else if (i_ctl.push) begin
            r_val <= i_above;
        end else if (i_ctl.pop) begin
            r_val <= i_below;
        end
    end

    assign o_val = r_val;

endmodule

`default_nettype wire

### rtl/fbpa_div.sv
// Radix-2 restoring divider of a byte offset by the block size, one quotient bit per cycle.
`default_nettype none

module fbpa_div (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [fbpa_pkg::OFFSET_W-1:0]  i_dividend,
    input  wire logic [fbpa_pkg::SIZE_W-1:0]    i_divisor,
    output logic                                o_done,
    output logic      [fbpa_pkg::OFFSET_W-1:0]  o_quotient,
    output logic      [fbpa_pkg::SIZE_W-1:0]    o_remainder
);

    localparam int CntW = $clog2(fbpa_pkg::OFFSET_W + 1);

    logic                           r_busy;
    logic                           r_done;
    logic [CntW-1:0]                r_cnt;
    logic [fbpa_pkg::OFFSET_W-1:0]  r_quo;
    logic [fbpa_pkg::SIZE_W-1:0]    r_rem;
    logic [fbpa_pkg::SIZE_W-1:0]    r_dvs;
    logic [fbpa_pkg::SIZE_W:0]      trial;
    logic [fbpa_pkg::SIZE_W:0]      diff;
    logic                           take;

    // The partial remainder stays below the divisor, so the trial value fits one extra bit.
    always_comb begin
        trial = {r_rem, r_quo[fbpa_pkg::OFFSET_W-1]};
        diff  = trial - {1'b0, r_dvs};
        take  = (trial >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CntW'(fbpa_pkg::OFFSET_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CntW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[fbpa_pkg::OFFSET_W-2:0], take};
            r_rem <= take ? diff[fbpa_pkg::SIZE_W-1:0] : trial[fbpa_pkg::SIZE_W-1:0];
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire

### rtl/fixed_block_pool_allocator.sv
// Fixed block pool allocator: LIFO free list held in a chain of stack cells.
// Allocate, pool reset and unused requests: the result is registered in the core, then
// moved to the output register. Free: the 20-step offset divider runs before the result.
// The core takes no new request until the last one is done; a result waits in
// the core until the output register is free. After reset or a block size write, input
// ready stays low while the size is rounded; reset rebuilds the list at once.
`default_nettype none

module fixed_block_pool_allocator #(
    parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF,
    parameter int ALIGNMENT  = fbpa_pkg::ALIGNMENT_DEF,
    parameter int MIN_BLOCK  = fbpa_pkg::MIN_BLOCK_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    fbpa_req_if.sink        i_req,
    fbpa_rsp_if.source      o_rsp,
    fbpa_cfg_if.sink        i_cfg
);

    // The count register is 9 bits wide, so no more blocks than that can ever be used.
    localparam int CntLimit = (1 << fbpa_pkg::CFG_COUNT_W) - 1;
    localparam int NumCells = (MAX_BLOCKS < CntLimit) ? MAX_BLOCKS : CntLimit;
    localparam int IdxW     = $clog2(NumCells);
    localparam int CntW     = $clog2(NumCells + 1);
    localparam int RstCount = (fbpa_pkg::CFG_COUNT_RST < NumCells) ?
                              fbpa_pkg::CFG_COUNT_RST : NumCells;
    localparam int ProdW    = IdxW + fbpa_pkg::SIZE_W;
    localparam int RecipW   = fbpa_pkg::CFG_SIZE_W + 1;
    localparam int RecipPW  = fbpa_pkg::CFG_SIZE_W + RecipW;

    localparam logic [RecipW-1:0] RecipM =
        RecipW'((1 << fbpa_pkg::CFG_SIZE_W) / ALIGNMENT);
    localparam logic [fbpa_pkg::SIZE_W-1:0] AlignC = fbpa_pkg::SIZE_W'(ALIGNMENT);
    localparam logic [fbpa_pkg::SIZE_W-1:0] MinSize =
        fbpa_pkg::SIZE_W'(((MIN_BLOCK + ALIGNMENT - 1) / ALIGNMENT) * ALIGNMENT);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;

    logic [1:0]                      r_state;
    logic [1:0]                      n_state;
    logic [CntW-1:0]                 r_eff_count;
    logic [CntW-1:0]                 n_count;
    logic [CntW-1:0]                 r_free_depth;
    logic [CntW-1:0]                 n_depth;
    logic [CntW-1:0]                 r_used;
    logic [CntW-1:0]                 n_used;
    logic [CntW-1:0]                 r_peak;
    logic [CntW-1:0]                 n_peak;
    logic [fbpa_pkg::FAIL_W-1:0]     r_fail;
    logic [fbpa_pkg::FAIL_W-1:0]     n_fail;
    logic [NumCells-1:0]             r_map;
    fbpa_pkg::t_result               r_pend;
    fbpa_pkg::t_result               r_out;
    logic                            r_out_valid;

    logic [fbpa_pkg::CFG_SIZE_W-1:0] r_req_size;
    logic                            r_geom_busy;
    logic                            r_geom_phase;
    logic [fbpa_pkg::SIZE_W-1:0]     r_q_est;
    logic [fbpa_pkg::SIZE_W-1:0]     r_eff_size;

    logic                            cfg_we;
    logic                            cfg_size_we;
    logic                            cfg_count_we;
    logic [fbpa_pkg::CFG_COUNT_W-1:0] cfg_count_raw;
    logic [CntW-1:0]                 cfg_count;
    logic                            in_acc;
    logic                            out_free;

    logic [RecipPW-1:0]              recip_prod;
    logic [fbpa_pkg::SIZE_W-1:0]     size_ext;
    logic [fbpa_pkg::SIZE_W-1:0]     rem_raw;
    logic [fbpa_pkg::SIZE_W-1:0]     rem_fix;
    logic [fbpa_pkg::SIZE_W-1:0]     size_rounded;
    logic [fbpa_pkg::SIZE_W-1:0]     size_eff;

    fbpa_pkg::t_stk_ctl              stk_ctl;
    logic [IdxW-1:0]                 cell_val [NumCells];
    logic [IdxW-1:0]                 top_idx;
    logic [IdxW-1:0]                 push_idx;
    logic [ProdW-1:0]                alloc_prod;

    logic                            div_start;
    logic                            div_done;
    logic [fbpa_pkg::OFFSET_W-1:0]   div_quo;
    logic [fbpa_pkg::SIZE_W-1:0]     div_rem;
    logic                            free_bad;

    logic                            rechain;
    logic                            map_we;
    logic                            map_bit;
    logic [IdxW-1:0]                 map_idx;
    logic                            finish;
    logic [fbpa_pkg::STATUS_W-1:0]   res_status;
    logic [fbpa_pkg::OFFSET_W-1:0]   res_off;

    // Handshakes.
    assign cfg_we       = i_cfg.valid && i_cfg.ready;
    assign cfg_size_we  = cfg_we && (i_cfg.index == fbpa_pkg::CFG_BLOCK_SIZE);
    assign cfg_count_we = cfg_we && (i_cfg.index == fbpa_pkg::CFG_BLOCK_COUNT);
    assign in_acc       = i_req.valid && i_req.ready;
    assign out_free     = !r_out_valid || o_rsp.ready;

    assign i_cfg.ready  = 1'b1;
    assign i_req.ready  = (r_state == S_IDLE) && !r_geom_busy;

    // A count of zero acts as one; anything above the pool limit saturates.
    assign cfg_count_raw = i_cfg.data[fbpa_pkg::CFG_COUNT_W-1:0];
    always_comb begin
        if (cfg_count_raw == '0) begin
            cfg_count = CntW'(1);
        end else if (int'(cfg_count_raw) > NumCells) begin
            cfg_count = CntW'(NumCells);
        end else begin
            cfg_count = CntW'(cfg_count_raw);
        end
    end

    // Block size round-up: a reciprocal multiply gives the quotient by the alignment
    // low by at most one, and the next cycle fixes the remainder with one subtract.
    assign recip_prod = RecipPW'(r_req_size) * RecipPW'(RecipM);
    assign size_ext   = fbpa_pkg::SIZE_W'(r_req_size);

    always_comb begin
        rem_raw = size_ext - fbpa_pkg::SIZE_W'(r_q_est * AlignC);
        rem_fix = (rem_raw >= AlignC) ? (rem_raw - AlignC) : rem_raw;
        size_rounded = (size_ext - rem_fix) + ((rem_fix != '0) ? AlignC : '0);
        size_eff = (size_rounded < MinSize) ? MinSize : size_rounded;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_size   <= fbpa_pkg::CFG_SIZE_W'(fbpa_pkg::CFG_SIZE_RST);
            r_geom_busy  <= 1'b1;
            r_geom_phase <= 1'b0;
        end else if (cfg_size_we) begin
            r_req_size   <= i_cfg.data[fbpa_pkg::CFG_SIZE_W-1:0];
            r_geom_busy  <= 1'b1;
            r_geom_phase <= 1'b0;
        end else if (r_geom_busy) begin
            if (r_geom_phase) begin
                r_geom_busy  <= 1'b0;
                r_geom_phase <= 1'b0;
            end else begin
                r_geom_phase <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_geom_busy && !r_geom_phase) begin
            r_q_est <= recip_prod[RecipPW-1:fbpa_pkg::CFG_SIZE_W];
        end
        if (r_geom_busy && r_geom_phase) begin
            r_eff_size <= size_eff;
        end
    end

    // Free stack: cell 0 is the top of the list.
    assign push_idx = div_quo[IdxW-1:0];

    for (genvar k = 0; k < NumCells; k++) begin : g_cell
        logic [IdxW-1:0] above;
        logic [IdxW-1:0] below;

        if (k == 0) begin : g_top
            assign above = push_idx;
        end else begin : g_mid
            assign above = cell_val[k-1];
        end

        if (k == NumCells - 1) begin : g_bottom
            assign below = '0;
        end else begin : g_inner
            assign below = cell_val[k+1];
        end

        fbpa_cell #(
            .IDX_W (IdxW),
            .IDX   (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (stk_ctl),
            .i_above (above),
            .i_below (below),
            .o_val   (cell_val[k])
        );
    end

    assign top_idx    = cell_val[0];
    assign alloc_prod = ProdW'(top_idx) * ProdW'(r_eff_size);

    fbpa_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (i_req.free_offset),
        .i_divisor   (r_eff_size),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // An offset at or past the pool end gives a quotient at or above the block count.
    always_comb begin
        free_bad = (div_quo >= fbpa_pkg::OFFSET_W'(r_eff_count)) || (div_rem != '0) ||
                   r_map[push_idx];
    end

    always_comb begin
        n_count    = r_eff_count;
        n_depth    = r_free_depth;
        n_used     = r_used;
        n_peak     = r_peak;
        n_fail     = r_fail;
        stk_ctl    = '0;
        rechain    = 1'b0;
        map_we     = 1'b0;
        map_bit    = 1'b0;
        map_idx    = top_idx;
        finish     = 1'b0;
        div_start  = 1'b0;
        res_status = fbpa_pkg::STATUS_OK;
        res_off    = '0;

        if (cfg_size_we || cfg_count_we) begin
            if (cfg_count_we) begin
                n_count = cfg_count;
            end
            rechain      = 1'b1;
            stk_ctl.load = 1'b1;
            n_depth      = n_count;
            n_used       = '0;
            n_peak       = '0;
            n_fail       = '0;
        end else if (in_acc) begin
            unique case (i_req.req_type)
                fbpa_pkg::REQ_ALLOC: begin
                    finish = 1'b1;
                    if (r_free_depth == '0) begin
                        res_status = fbpa_pkg::STATUS_EXHAUSTED;
                        if (r_fail != '1) begin
                            n_fail = r_fail + 1'b1;
                        end
                    end else begin
                        stk_ctl.pop = 1'b1;
                        n_depth     = r_free_depth - 1'b1;
                        n_used      = r_used + 1'b1;
                        if (n_used > r_peak) begin
                            n_peak = n_used;
                        end
                        map_we  = 1'b1;
                        map_bit = 1'b0;
                        map_idx = top_idx;
                        res_off = fbpa_pkg::OFFSET_W'(alloc_prod);
                    end
                end
                fbpa_pkg::REQ_FREE: begin
                    div_start = 1'b1;
                end
                fbpa_pkg::REQ_RESET: begin
                    finish       = 1'b1;
                    rechain      = 1'b1;
                    stk_ctl.load = 1'b1;
                    n_depth      = r_eff_count;
                    n_used       = '0;
                end
                default: begin
                    finish = 1'b1;
                end
            endcase
        end else if (r_state == S_DIV && div_done) begin
            finish = 1'b1;
            if (free_bad) begin
                res_status = fbpa_pkg::STATUS_BAD_FREE;
            end else begin
                stk_ctl.push = 1'b1;
                n_depth      = r_free_depth + 1'b1;
                if (r_used != '0) begin
                    n_used = r_used - 1'b1;
                end
                map_we  = 1'b1;
                map_bit = 1'b1;
                map_idx = push_idx;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (div_start) begin
                    n_state = S_DIV;
                end else if (finish) begin
                    n_state = S_WAIT;
                end
            end
            S_DIV: begin
                if (finish) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_eff_count  <= CntW'(RstCount);
            r_free_depth <= CntW'(RstCount);
            r_used       <= '0;
            r_peak       <= '0;
            r_fail       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_eff_count  <= n_count;
            r_free_depth <= n_depth;
            r_used       <= n_used;
            r_peak       <= n_peak;
            r_fail       <= n_fail;
            if (r_state == S_WAIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Free map: one bit per block, set while the block sits in the free list.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NumCells; i++) begin
                r_map[i] <= (i < RstCount);
            end
        end else if (rechain) begin
            for (int i = 0; i < NumCells; i++) begin
                r_map[i] <= (i < int'(n_count));
            end
        end else if (map_we) begin
            r_map[map_idx] <= map_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_pend.status        <= res_status;
            r_pend.block_offset  <= res_off;
            r_pend.blocks_in_use <= fbpa_pkg::COUNT_OUT_W'(n_used);
            r_pend.peak_in_use   <= fbpa_pkg::COUNT_OUT_W'(n_peak);
            r_pend.failed_allocs <= n_fail;
        end
        if (r_state == S_WAIT && out_free) begin
            r_out <= r_pend;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out.status;
    assign o_rsp.block_offset  = r_out.block_offset;
    assign o_rsp.blocks_in_use = r_out.blocks_in_use;
    assign o_rsp.peak_in_use   = r_out.peak_in_use;
    assign o_rsp.failed_allocs = r_out.failed_allocs;

`ifndef SYNTHESIS
    a_depth_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CntW+1)'(r_free_depth) + (CntW+1)'(r_used) == (CntW+1)'(r_eff_count))
        else $error("free depth and used count do not add up to the pool size");

    a_map_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_map) == int'(r_free_depth))
        else $error("free map population differs from the free list depth");

    a_peak_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_peak >= r_used)
        else $error("peak count fell below the used count");

    a_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside of a free operation");
`endif

endmodule

`default_nettype wire
